>>> rtl/robin_hood_hash_table_unit_macros.svh
// Assertion macros for the Robin Hood hash table unit
`ifndef ROBIN_HOOD_HASH_TABLE_UNIT_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_UNIT_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define RHHT_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("rhht assertion failed");

// check that a condition implies a consequence in the next cycle
`define RHHT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("rhht assertion failed");

`endif

>>> rtl/rhht_pkg.sv
// Shared types and codes for the Robin Hood hash table unit
`default_nettype none
package rhht_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [10:0] free_slots;
        logic        status;
    } result_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR,
        OP_RC_INIT,
        OP_RC_STEP,
        OP_DIV,
        OP_PROBE_INIT,
        OP_READ,
        OP_FIND_NEXT,
        OP_HIT,
        OP_MISS,
        OP_FULL,
        OP_INS_INIT,
        OP_INS_PUT,
        OP_INS_SWAP,
        OP_INS_NEXT,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic       clr_last;
        logic       rc_last;
        logic       div_last;
        logic       dirty;
        logic [1:0] command;
        logic       q_used;
        logic       q_match;
        logic       q_short;
        logic       q_end;
        logic       full;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/rhht_ctrl.sv
// Controller state machine for the Robin Hood hash table unit
`default_nettype none
module rhht_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rhht_pkg::stat_t stat,
    output rhht_pkg::ctl_t      ctl
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RC_INIT,
        S_RC,
        S_RC_TAIL,
        S_DISP,
        S_DIV,
        S_PINIT,
        S_FRD,
        S_FCHK,
        S_IRD,
        S_ICHK
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = rhht_pkg::OP_NOP;
        case (state_reg)
            S_CLR:
            begin
                ctl.op = rhht_pkg::OP_CLR;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = rhht_pkg::OP_LOAD;
                    state_next = stat.dirty ? S_RC_INIT : S_DISP;
                end
            end
            S_RC_INIT:
            begin
                ctl.op     = rhht_pkg::OP_RC_INIT;
                state_next = S_RC;
            end
            S_RC:
            begin
                ctl.op = rhht_pkg::OP_RC_STEP;
                if (stat.rc_last)
                    state_next = S_RC_TAIL;
            end
            S_RC_TAIL:
                state_next = S_DISP;
            S_DISP:
            begin
                if (stat.command == rhht_pkg::CMD_ADD || stat.command == rhht_pkg::CMD_LOOKUP)
                    state_next = S_DIV;
                else
                begin
                    ctl.op     = rhht_pkg::OP_DONE;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                ctl.op = rhht_pkg::OP_DIV;
                if (stat.div_last)
                    state_next = S_PINIT;
            end
            S_PINIT:
            begin
                ctl.op     = rhht_pkg::OP_PROBE_INIT;
                state_next = S_FRD;
            end
            S_FRD:
            begin
                ctl.op     = rhht_pkg::OP_READ;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (stat.q_used && !stat.q_short && stat.q_match)
                begin
                    ctl.op     = rhht_pkg::OP_HIT;
                    state_next = S_IDLE;
                end
                else if (stat.q_used && !stat.q_short && !stat.q_end)
                begin
                    ctl.op     = rhht_pkg::OP_FIND_NEXT;
                    state_next = S_FRD;
                end
                else if (stat.command == rhht_pkg::CMD_LOOKUP)
                begin
                    ctl.op     = rhht_pkg::OP_MISS;
                    state_next = S_IDLE;
                end
                else if (stat.full)
                begin
                    ctl.op     = rhht_pkg::OP_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = rhht_pkg::OP_INS_INIT;
                    state_next = S_IRD;
                end
            end
            S_IRD:
            begin
                ctl.op     = rhht_pkg::OP_READ;
                state_next = S_ICHK;
            end
            S_ICHK:
            begin
                state_next = S_IRD;
                if (!stat.q_used)
                begin
                    ctl.op     = rhht_pkg::OP_INS_PUT;
                    state_next = S_IDLE;
                end
                else if (stat.q_short)
                    ctl.op = rhht_pkg::OP_INS_SWAP;
                else
                    ctl.op = rhht_pkg::OP_INS_NEXT;
            end
            default:
                state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

>>> rtl/rhht_dp.sv
// Datapath for the Robin Hood hash table unit: slot memory, divider, probe registers
`default_nettype none
module rhht_dp #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rhht_pkg::ctl_t    ctl,
    output rhht_pkg::stat_t        stat,
    input  wire rhht_pkg::item_t   item,
    input  wire logic              cfg_we,
    input  wire logic [10:0]       cfg_wdata,
    output logic                   result_valid,
    output rhht_pkg::result_t      result
);

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int CW  = $clog2(TABLE_SLOTS + 1);
    localparam int CFW = (CW > 11) ? CW : 11;

    typedef struct packed {
        logic                used;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         hash;
        logic [31:0]         value;
        logic [SW-1:0]       plen;
    } entry_t;

    entry_t mem [TABLE_SLOTS];
    entry_t q_reg;

    logic [CFW-1:0]      cfg_reg;
    logic                dirty_reg;
    rhht_pkg::item_t     in_reg;
    logic [CW-1:0]       rem_reg;
    logic [4:0]          div_cnt_reg;
    logic [SW-1:0]       idx_reg;
    logic [SW-1:0]       dist_reg;
    logic [SW-1:0]       max_pl_reg;
    logic [KEY_BITS-1:0] car_key_reg;
    logic [31:0]         car_hash_reg;
    logic [31:0]         car_val_reg;
    logic [SW-1:0]       clr_addr_reg;
    logic [SW-1:0]       rc_addr_reg;
    logic                rc_pend_reg;
    logic [CW-1:0]       used_cnt_reg;
    logic                res_valid_reg;
    rhht_pkg::result_t   res_reg;

    logic [CW-1:0]       n;
    logic [KEY_BITS-1:0] key_k;
    logic [SW-1:0]       idx_nx;
    logic [CW:0]         rem_sh;
    logic [CW:0]         rem_nx;
    logic [SW-1:0]       step_base;
    logic [SW-1:0]       step_pl;
    logic [CW-1:0]       free_now;
    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [SW-1:0]       rd_addr;
    entry_t              carry;

    always_comb
    begin
        if (cfg_reg == '0)
            n = CW'(1);
        else if (32'(cfg_reg) > 32'(TABLE_SLOTS))
            n = CW'(TABLE_SLOTS);
        else
            n = CW'(cfg_reg);
    end

    assign key_k    = KEY_BITS'(in_reg.key);
    assign idx_nx   = ((CW'(idx_reg) + CW'(1)) == n) ? '0 : idx_reg + SW'(1);
    assign rem_sh   = {rem_reg, in_reg.key_hash[5'd31 - div_cnt_reg]};
    assign rem_nx   = (rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh;
    assign step_base = (ctl.op == rhht_pkg::OP_INS_SWAP) ? q_reg.plen : dist_reg;
    assign step_pl  = step_base + SW'(1);
    assign free_now = n - used_cnt_reg;

    assign carry.used  = 1'b1;
    assign carry.key   = car_key_reg;
    assign carry.hash  = car_hash_reg;
    assign carry.value = car_val_reg;
    assign carry.plen  = dist_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = carry;
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        case (ctl.op)
            rhht_pkg::OP_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            rhht_pkg::OP_RC_STEP:
            begin
                rd_en   = 1'b1;
                rd_addr = rc_addr_reg;
            end
            rhht_pkg::OP_READ:
                rd_en = 1'b1;
            rhht_pkg::OP_HIT:
            begin
                wr_en         = (in_reg.command == rhht_pkg::CMD_ADD);
                wr_data       = q_reg;
                wr_data.value = in_reg.value;
            end
            rhht_pkg::OP_INS_PUT,
            rhht_pkg::OP_INS_SWAP:
                wr_en = 1'b1;
            default:
                wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFW'(TABLE_SLOTS);
            dirty_reg     <= 1'b0;
            max_pl_reg    <= '0;
            clr_addr_reg  <= '0;
            rc_pend_reg   <= 1'b0;
            used_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rc_pend_reg   <= (ctl.op == rhht_pkg::OP_RC_STEP);
            res_valid_reg <= (ctl.op == rhht_pkg::OP_INS_PUT) ||
                             (ctl.op == rhht_pkg::OP_HIT) ||
                             (ctl.op == rhht_pkg::OP_MISS) ||
                             (ctl.op == rhht_pkg::OP_FULL) ||
                             (ctl.op == rhht_pkg::OP_DONE);
            if (cfg_we)
            begin
                cfg_reg   <= CFW'(cfg_wdata);
                dirty_reg <= 1'b1;
            end
            if (rc_pend_reg && q_reg.used)
                used_cnt_reg <= used_cnt_reg + CW'(1);
            case (ctl.op)
                rhht_pkg::OP_CLR:
                    clr_addr_reg <= clr_addr_reg + SW'(1);
                rhht_pkg::OP_RC_INIT:
                begin
                    dirty_reg    <= 1'b0;
                    used_cnt_reg <= '0;
                end
                rhht_pkg::OP_INS_PUT:
                    used_cnt_reg <= used_cnt_reg + CW'(1);
                rhht_pkg::OP_INS_SWAP,
                rhht_pkg::OP_INS_NEXT:
                begin
                    if (step_pl > max_pl_reg)
                        max_pl_reg <= step_pl;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            rhht_pkg::OP_LOAD:
            begin
                in_reg      <= item;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            rhht_pkg::OP_RC_INIT:
                rc_addr_reg <= '0;
            rhht_pkg::OP_RC_STEP:
                rc_addr_reg <= rc_addr_reg + SW'(1);
            rhht_pkg::OP_DIV:
            begin
                rem_reg     <= CW'(rem_nx);
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            rhht_pkg::OP_PROBE_INIT:
            begin
                idx_reg  <= SW'(rem_reg);
                dist_reg <= '0;
            end
            rhht_pkg::OP_FIND_NEXT,
            rhht_pkg::OP_INS_NEXT:
            begin
                idx_reg  <= idx_nx;
                dist_reg <= dist_reg + SW'(1);
            end
            rhht_pkg::OP_INS_INIT:
            begin
                idx_reg      <= SW'(rem_reg);
                dist_reg     <= '0;
                car_key_reg  <= key_k;
                car_hash_reg <= in_reg.key_hash;
                car_val_reg  <= in_reg.value;
            end
            rhht_pkg::OP_INS_SWAP:
            begin
                idx_reg      <= idx_nx;
                dist_reg     <= step_pl;
                car_key_reg  <= q_reg.key;
                car_hash_reg <= q_reg.hash;
                car_val_reg  <= q_reg.value;
            end
            rhht_pkg::OP_HIT:
            begin
                res_reg.found      <= 1'b1;
                res_reg.value_out  <= (in_reg.command == rhht_pkg::CMD_LOOKUP) ?
                                      q_reg.value : 32'd0;
                res_reg.free_slots <= 11'(free_now);
                res_reg.status     <= 1'b0;
            end
            rhht_pkg::OP_FULL:
            begin
                res_reg.found      <= 1'b0;
                res_reg.value_out  <= 32'd0;
                res_reg.free_slots <= 11'(free_now);
                res_reg.status     <= 1'b1;
            end
            rhht_pkg::OP_INS_PUT:
            begin
                res_reg.found      <= 1'b0;
                res_reg.value_out  <= 32'd0;
                res_reg.free_slots <= 11'(free_now - CW'(1));
                res_reg.status     <= 1'b0;
            end
            rhht_pkg::OP_MISS,
            rhht_pkg::OP_DONE:
            begin
                res_reg.found      <= 1'b0;
                res_reg.value_out  <= 32'd0;
                res_reg.free_slots <= 11'(free_now);
                res_reg.status     <= 1'b0;
            end
            default:
                res_reg <= res_reg;
        endcase
    end

    assign stat.clr_last = (clr_addr_reg == SW'(TABLE_SLOTS - 1));
    assign stat.rc_last  = ((CW'(rc_addr_reg) + CW'(1)) == n);
    assign stat.div_last = (div_cnt_reg == 5'd31);
    assign stat.dirty    = dirty_reg;
    assign stat.command  = in_reg.command;
    assign stat.q_used   = q_reg.used;
    assign stat.q_match  = (q_reg.hash == in_reg.key_hash) && (q_reg.key == key_k);
    assign stat.q_short  = (q_reg.plen < dist_reg);
    assign stat.q_end    = (dist_reg == max_pl_reg) || ((CW'(dist_reg) + CW'(1)) == n);
    assign stat.full     = (used_cnt_reg == n);

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

>>> rtl/robin_hood_hash_table_unit.sv
// Top level of the Robin Hood hash table unit
//
// channel   signals                 handshake
// item in   start, item, busy       taken when start is high and busy is low
// result    result_valid, result    one cycle per item, cannot be held off
// config    cfg_we, cfg_wdata       slot count, written on any cycle with cfg_we
//
// After reset a clearing pass over all TABLE_SLOTS slots runs with busy high.
// The first item after a slot count write first recounts the used slots.
// Add and lookup run the hash modulo divider, then read and check each probed slot,
// and an insert walks and swaps slots; count and unknown commands skip the divider.
// The result is registered after the last step; the receiver cannot stall.
`default_nettype none
module robin_hood_hash_table_unit #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rhht_pkg::item_t   item,
    input  wire logic              cfg_we,
    input  wire logic [10:0]       cfg_wdata,
    output logic                   result_valid,
    output rhht_pkg::result_t      result
);

    rhht_pkg::ctl_t  ctl;
    rhht_pkg::stat_t stat;

    rhht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    rhht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

>>> rtl/rhht_chk.sv
// Port checker for the Robin Hood hash table unit and its bind
`default_nettype none
`include "robin_hood_hash_table_unit_macros.svh"
module rhht_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              result_valid,
    input wire rhht_pkg::result_t result
);

    `RHHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `RHHT_ASSERT_NEXT(a_single_pulse, clk, rst_n, result_valid, !result_valid)
    `RHHT_ASSERT_NOW(a_found_ok, clk, rst_n, result_valid, !(result.found && result.status))
    `RHHT_ASSERT_NOW(a_full_free, clk, rst_n, result_valid && result.status,
                     result.free_slots == 11'd0)

endmodule

bind robin_hood_hash_table_unit rhht_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

>>> sim/robin_hood_hash_table_unit_checker.sv
// Predictor and result checker for the Robin Hood hash table unit
`default_nettype none
module robin_hood_hash_table_unit_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire rhht_pkg::item_t   item,
    input  wire logic              cfg_we,
    input  wire logic [10:0]       cfg_wdata,
    input  wire logic              result_valid,
    input  wire rhht_pkg::result_t result,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1024;

    logic              slot_used  [SLOTS];
    logic [31:0]       slot_key   [SLOTS];
    logic [31:0]       slot_hash  [SLOTS];
    logic [31:0]       slot_val   [SLOTS];
    int unsigned       slot_dist  [SLOTS];
    int unsigned       max_dist;
    logic [10:0]       slot_count;
    rhht_pkg::result_t expected_results[$];
    int                items_taken;
    int                results_seen;

    assign pending = items_taken - results_seen;

    function automatic int unsigned live_slots();
        if (slot_count == 0)
            return 1;
        if (slot_count > SLOTS)
            return SLOTS;
        return slot_count;
    endfunction

    function automatic int unsigned free_in(int unsigned n);
        int unsigned sum;
        sum = 0;
        for (int unsigned i = 0; i < n; i++)
            if (!slot_used[i])
                sum++;
        return sum;
    endfunction

    function automatic int locate(logic [31:0] k, logic [31:0] h, int unsigned n);
        int unsigned home;
        int unsigned idx;
        home = h % n;
        for (int unsigned d = 0; d <= max_dist && d < n; d++)
        begin
            idx = (home + d) % n;
            if (!slot_used[idx] || slot_dist[idx] < d)
                return -1;
            if (slot_hash[idx] == h && slot_key[idx] == k)
                return idx;
        end
        return -1;
    endfunction

    task automatic apply_item(input rhht_pkg::item_t it, output rhht_pkg::result_t r);
        int unsigned n;
        int unsigned idx;
        int          hit;
        logic [31:0] ck, ch, cv, tk, th, tv;
        int unsigned cp, tp;
        n = live_slots();
        r = '0;
        if (it.command == rhht_pkg::CMD_ADD)
        begin
            hit = locate(it.key, it.key_hash, n);
            if (hit >= 0)
            begin
                slot_val[hit] = it.value;
                r.found = 1'b1;
            end
            else if (free_in(n) == 0)
            begin
                r.status = 1'b1;
            end
            else
            begin
                ck = it.key;
                ch = it.key_hash;
                cv = it.value;
                cp = 0;
                idx = it.key_hash % n;
                while (slot_used[idx])
                begin
                    if (cp > slot_dist[idx])
                    begin
                        tk = slot_key[idx];
                        th = slot_hash[idx];
                        tv = slot_val[idx];
                        tp = slot_dist[idx];
                        slot_key[idx] = ck;
                        slot_hash[idx] = ch;
                        slot_val[idx] = cv;
                        slot_dist[idx] = cp;
                        ck = tk;
                        ch = th;
                        cv = tv;
                        cp = tp;
                    end
                    idx = (idx + 1) % n;
                    cp++;
                    if (cp > max_dist)
                        max_dist = cp;
                end
                slot_used[idx] = 1'b1;
                slot_key[idx] = ck;
                slot_hash[idx] = ch;
                slot_val[idx] = cv;
                slot_dist[idx] = cp;
            end
        end
        else if (it.command == rhht_pkg::CMD_LOOKUP)
        begin
            hit = locate(it.key, it.key_hash, n);
            if (hit >= 0)
            begin
                r.found = 1'b1;
                r.value_out = slot_val[hit];
            end
        end
        r.free_slots = 11'(free_in(n));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rhht_pkg::result_t want;
        rhht_pkg::result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            max_dist = 0;
            slot_count = 11'(SLOTS);
            expected_results.delete();
            items_taken <= 0;
            results_seen <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                results_seen <= results_seen + 1;
                got = result;
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                    if (got.value_out !== want.value_out)
                        $error("value_out: expected %0h, actual %0h",
                               want.value_out, got.value_out);
                    if (got.free_slots !== want.free_slots)
                        $error("free_slots: expected %0d, actual %0d",
                               want.free_slots, got.free_slots);
                    if (got.status !== want.status)
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (cfg_we)
                slot_count = cfg_wdata;
            if (start && !busy)
            begin
                apply_item(item, want);
                expected_results.push_back(want);
                items_taken <= items_taken + 1;
            end
        end
    end
endmodule
`default_nettype wire

>>> sim/robin_hood_hash_table_unit_tb.sv
// Testbench top for the Robin Hood hash table unit: stimulus and verdict
`default_nettype none
module robin_hood_hash_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    rhht_pkg::item_t   item;
    logic              cfg_we;
    logic [10:0]       cfg_wdata;
    logic              result_valid;
    rhht_pkg::result_t result;
    int                fail_count;
    int                pending;
    bit                burst;

    robin_hood_hash_table_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    robin_hood_hash_table_unit_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic issue(input logic [1:0] cmd, input logic [31:0] k,
                         input logic [31:0] h, input logic [31:0] v);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= '{command: cmd, key: k, key_hash: h, value: v};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_slots(input logic [10:0] cnt);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] mix(logic [31:0] k);
        return k * 32'h9E3779B1;
    endfunction

    initial
    begin
        logic [31:0] kbase;
        logic [31:0] k, h;
        logic [1:0]  cmd;
        int          cur;
        int          cnt;
        int          pool;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        burst = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(rhht_pkg::CMD_COUNT, 0, 0, 0);
        issue(rhht_pkg::CMD_LOOKUP, 0, 0, 0);
        issue(rhht_pkg::CMD_ADD, 0, 0, 0);
        issue(rhht_pkg::CMD_ADD, '1, '1, '1);
        issue(rhht_pkg::CMD_LOOKUP, 0, 0, 0);
        issue(rhht_pkg::CMD_LOOKUP, '1, '1, 0);
        issue(rhht_pkg::CMD_ADD, 0, 0, 32'h5A5A_A5A5);
        issue(rhht_pkg::CMD_LOOKUP, 0, 0, 0);
        issue(CMD_UNKNOWN, '1, '1, '1);
        issue(rhht_pkg::CMD_ADD, 1, 5, 11);
        issue(rhht_pkg::CMD_ADD, 2, 5, 12);
        issue(rhht_pkg::CMD_ADD, 3, 6, 13);
        issue(rhht_pkg::CMD_ADD, 4, 5, 14);
        issue(rhht_pkg::CMD_LOOKUP, 4, 5, 0);
        issue(rhht_pkg::CMD_LOOKUP, 3, 5, 0);
        set_slots(11'd4);
        for (int i = 0; i < 4; i++)
            issue(rhht_pkg::CMD_ADD, 100 + i, i, i);
        issue(rhht_pkg::CMD_LOOKUP, 102, 2, 0);
        set_slots(11'd0);
        issue(rhht_pkg::CMD_ADD, 200, 7, 7);
        issue(rhht_pkg::CMD_LOOKUP, 0, 0, 0);
        set_slots(11'd2047);
        issue(rhht_pkg::CMD_LOOKUP, 4, 5, 0);
        issue(rhht_pkg::CMD_COUNT, 0, 0, 0);
        drain();

        cur = 8;
        for (int ph = 0; ph < 22; ph++)
        begin
            case ($urandom_range(0, 5))
                0: cnt = $urandom_range(0, 6);
                1: cnt = $urandom_range(1025, 2047);
                default:
                begin
                    cur = cur + $urandom_range(8, 60);
                    if (cur > 1024)
                        cur = $urandom_range(8, 1024);
                    cnt = cur;
                end
            endcase
            set_slots(11'(cnt));
            burst = ($urandom_range(0, 3) == 0);
            kbase = $urandom;
            pool = (cnt > 0 && cnt < 64) ? cnt + 4 : 48;
            for (int i = 0; i < 50; i++)
            begin
                if (i == 25)
                    drain();
                k = kbase + $urandom_range(0, pool - 1);
                case ($urandom_range(0, 9))
                    0: h = $urandom;
                    1, 2: h = $urandom_range(0, 7);
                    default: h = mix(k);
                endcase
                case ($urandom_range(0, 19))
                    0: cmd = CMD_UNKNOWN;
                    1, 2: cmd = rhht_pkg::CMD_COUNT;
                    3: begin cmd = rhht_pkg::CMD_LOOKUP; k = $urandom; end
                    4, 5, 6, 7, 8, 9, 10: cmd = rhht_pkg::CMD_LOOKUP;
                    default: cmd = rhht_pkg::CMD_ADD;
                endcase
                issue(cmd, k, h, $urandom);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/rhht_pkg.sv
rtl/rhht_ctrl.sv
rtl/rhht_dp.sv
rtl/robin_hood_hash_table_unit.sv
rtl/rhht_chk.sv
sim/robin_hood_hash_table_unit_checker.sv
sim/robin_hood_hash_table_unit_tb.sv
